// ===== rtl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the polar/cartesian converter
// Word types of both channels, the CORDIC stage record, fixed-point constants
// and the arctangent table.
// ----------------------------------------------------------------------------
package pcc_pkg;

	// field and datapath widths
	localparam int DATA_W     = 32;
	localparam int CX_W       = 52;   // cordic coordinates, Q32 with headroom
	localparam int Z_W        = 34;   // cordic angle, Q2.30 with headroom
	localparam int ANG_W      = 19;   // clamped input angle, Q2.16
	localparam int PROD_W     = 63;   // length times gain
	localparam int GAIN_W     = 30;
	localparam int MAG_W      = 49;   // final cordic x magnitude
	localparam int SPLIT      = 25;   // low part of the gain multiply
	localparam int GUARD_SH   = 16;   // Q15.16 to Q32
	localparam int ANG_SH     = 14;   // Q15.16 to Q2.30
	localparam int RND_W      = CX_W - GUARD_SH;
	localparam int ANG_OUT_W  = Z_W - ANG_SH;
	localparam int SUM_W      = MAG_W + GAIN_W;

	// function select codes
	localparam logic FUNC_TO_POLAR = 1'b0;
	localparam logic FUNC_TO_CART  = 1'b1;

	// fixed-point constants
	localparam logic [GAIN_W-1:0]        GAIN_Q30    = 30'd652032874;
	localparam logic signed [Z_W-1:0]    PI_Q30      = 34'sd3373259426;
	localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [DATA_W-1:0] HALF_PI_Q16 = 32'sd102944;
	localparam logic signed [ANG_W-1:0]  ANGLE_LIMIT = 19'sd205887;
	localparam logic signed [DATA_W-1:0] SAT_MAX     = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN     = 32'sh80000000;
	localparam logic signed [Z_W-1:0]    ANG_RND     = 34'sd8192;
	localparam logic signed [CX_W-1:0]   CX_RND      = 52'sd32768;

	// request word
	typedef struct packed {
		logic                     func;
		logic signed [DATA_W-1:0] first_in;
		logic signed [DATA_W-1:0] second_in;
	} in_word_t;

	// response word
	typedef struct packed {
		logic signed [DATA_W-1:0] first_out;
		logic signed [DATA_W-1:0] second_out;
		logic                     overflow;
	} out_word_t;

	// record carried through the rotation stages
	typedef struct packed {
		logic                     func;
		logic                     zero_x;
		logic                     ovf;
		logic signed [DATA_W-1:0] y_raw;
		logic signed [CX_W-1:0]   x;
		logic signed [CX_W-1:0]   y;
		logic signed [Z_W-1:0]    z;
	} cordic_t;

	// atan(2^-i) in Q2.30, truncated except entries 27 to 29, which are rounded
	function automatic logic [GAIN_W-1:0] atan_entry(input int idx);
		case (idx)
			0:       return 30'h3243F6A8;
			1:       return 30'h1DAC6705;
			2:       return 30'h0FADBAFC;
			3:       return 30'h07F56EA6;
			4:       return 30'h03FEAB76;
			5:       return 30'h01FFD55B;
			6:       return 30'h00FFFAAA;
			7:       return 30'h007FFF55;
			8:       return 30'h003FFFEA;
			9:       return 30'h001FFFFD;
			10:      return 30'h000FFFFF;
			11:      return 30'h0007FFFF;
			12:      return 30'h0003FFFF;
			13:      return 30'h0001FFFF;
			14:      return 30'h0000FFFF;
			15:      return 30'h00007FFF;
			16:      return 30'h00003FFF;
			17:      return 30'h00001FFF;
			18:      return 30'h00000FFF;
			19:      return 30'h000007FF;
			20:      return 30'h000003FF;
			21:      return 30'h000001FF;
			22:      return 30'h000000FF;
			23:      return 30'h0000007F;
			24:      return 30'h0000003F;
			25:      return 30'h0000001F;
			26:      return 30'h0000000F;
			27:      return 30'h00000008;
			28:      return 30'h00000004;
			29:      return 30'h00000002;
			default: return '0;
		endcase
	endfunction

endpackage

// ===== rtl/pcc_pre.sv =====
// ----------------------------------------------------------------------------
// pcc_pre: input conditioning for the rotation pipeline
// Two stages: sign handling, angle clamp and gain pre-scale multiply, then
// quadrant fold and setup of the cordic record.
// ----------------------------------------------------------------------------
module pcc_pre (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  pcc_pkg::in_word_t  in_word,
	output logic               out_vld,
	output pcc_pkg::cordic_t   out_data
);

	logic signed [pcc_pkg::DATA_W-1:0] x_c, y_c;
	logic signed [pcc_pkg::DATA_W:0]   xe_c, ye_c, xa_c, yn_c;
	logic signed [pcc_pkg::ANG_W-1:0]  ang_c;
	logic                              clamp_c;
	logic signed [pcc_pkg::PROD_W-1:0] prod_c;

	logic                              vld_s1;
	logic                              func_s1, zero_x_s1, ovf_s1;
	logic signed [pcc_pkg::DATA_W-1:0] y_s1;
	logic signed [pcc_pkg::DATA_W:0]   xa_s1, yn_s1;
	logic signed [pcc_pkg::ANG_W-1:0]  ang_s1;
	logic signed [pcc_pkg::PROD_W-1:0] prod_s1;

	logic signed [pcc_pkg::PROD_W-1:0] prod_sh_c;
	logic signed [pcc_pkg::CX_W-1:0]   cxp_c;
	logic signed [pcc_pkg::Z_W-1:0]    zc_c;
	pcc_pkg::cordic_t                  rec_c;

	logic                              vld_s2;
	pcc_pkg::cordic_t                  data_s2;

	// stage 1: absolute x, mirrored y, angle clamp, length times gain
	always_comb begin
		x_c  = in_word.first_in;
		y_c  = in_word.second_in;
		xe_c = {x_c[pcc_pkg::DATA_W-1], x_c};
		ye_c = {y_c[pcc_pkg::DATA_W-1], y_c};
		xa_c = x_c[pcc_pkg::DATA_W-1] ? -xe_c : xe_c;
		yn_c = x_c[pcc_pkg::DATA_W-1] ? -ye_c : ye_c;
		clamp_c = 1'b0;
		if (y_c > pcc_pkg::ANGLE_LIMIT) begin
			ang_c   = pcc_pkg::ANGLE_LIMIT;
			clamp_c = 1'b1;
		end else if (y_c < -pcc_pkg::ANGLE_LIMIT) begin
			ang_c   = -pcc_pkg::ANGLE_LIMIT;
			clamp_c = 1'b1;
		end else begin
			ang_c = y_c[pcc_pkg::ANG_W-1:0];
		end
		prod_c = pcc_pkg::PROD_W'(x_c)
			* pcc_pkg::PROD_W'($signed({1'b0, pcc_pkg::GAIN_Q30}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		func_s1   <= in_word.func;
		zero_x_s1 <= (x_c == '0);
		ovf_s1    <= (in_word.func == pcc_pkg::FUNC_TO_CART) && clamp_c;
		y_s1      <= y_c;
		xa_s1     <= xa_c;
		yn_s1     <= yn_c;
		ang_s1    <= ang_c;
		prod_s1   <= prod_c;
	end

	// stage 2: quadrant fold for rotation, guard bits for vectoring
	always_comb begin
		prod_sh_c = prod_s1 >>> pcc_pkg::ANG_SH;
		cxp_c     = prod_sh_c[pcc_pkg::CX_W-1:0];
		zc_c      = {{(pcc_pkg::Z_W-pcc_pkg::ANG_W-pcc_pkg::ANG_SH){ang_s1[pcc_pkg::ANG_W-1]}},
			ang_s1, {pcc_pkg::ANG_SH{1'b0}}};
		rec_c.func   = func_s1;
		rec_c.zero_x = zero_x_s1;
		rec_c.ovf    = ovf_s1;
		rec_c.y_raw  = y_s1;
		if (func_s1 == pcc_pkg::FUNC_TO_CART) begin
			rec_c.y = '0;
			if (zc_c > pcc_pkg::HALF_PI_Q30) begin
				rec_c.z = zc_c - pcc_pkg::PI_Q30;
				rec_c.x = -cxp_c;
			end else if (zc_c < -pcc_pkg::HALF_PI_Q30) begin
				rec_c.z = zc_c + pcc_pkg::PI_Q30;
				rec_c.x = -cxp_c;
			end else begin
				rec_c.z = zc_c;
				rec_c.x = cxp_c;
			end
		end else begin
			rec_c.x = {{(pcc_pkg::CX_W-pcc_pkg::DATA_W-1-pcc_pkg::GUARD_SH){xa_s1[pcc_pkg::DATA_W]}},
				xa_s1, {pcc_pkg::GUARD_SH{1'b0}}};
			rec_c.y = {{(pcc_pkg::CX_W-pcc_pkg::DATA_W-1-pcc_pkg::GUARD_SH){yn_s1[pcc_pkg::DATA_W]}},
				yn_s1, {pcc_pkg::GUARD_SH{1'b0}}};
			rec_c.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= rec_c;
	end

	assign out_vld  = vld_s2;
	assign out_data = data_s2;

endmodule

// ===== rtl/pcc_stage.sv =====
// ----------------------------------------------------------------------------
// pcc_stage: one cordic micro-rotation
// Vectoring steers by the sign of y, rotation by the sign of the residual
// angle; both share the same add/subtract datapath.
// ----------------------------------------------------------------------------
module pcc_stage #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  pcc_pkg::cordic_t in_data,
	output logic             out_vld,
	output pcc_pkg::cordic_t out_data
);

	logic signed [pcc_pkg::CX_W-1:0] xi_c, yi_c, xs_c, ys_c;
	logic signed [pcc_pkg::Z_W-1:0]  zi_c, at_c;
	logic                            cw_c;
	pcc_pkg::cordic_t                rec_c;

	logic                            vld_s1;
	pcc_pkg::cordic_t                data_s1;

	// shifted terms and rotation direction
	always_comb begin
		xi_c = in_data.x;
		yi_c = in_data.y;
		zi_c = in_data.z;
		xs_c = xi_c >>> IDX;
		ys_c = yi_c >>> IDX;
		at_c = {{(pcc_pkg::Z_W-pcc_pkg::GAIN_W){1'b0}}, pcc_pkg::atan_entry(IDX)};
		cw_c = (in_data.func == pcc_pkg::FUNC_TO_CART) ? zi_c[pcc_pkg::Z_W-1]
			: ~yi_c[pcc_pkg::CX_W-1];
		rec_c   = in_data;
		rec_c.x = cw_c ? xi_c + ys_c : xi_c - ys_c;
		rec_c.y = cw_c ? yi_c - xs_c : yi_c + xs_c;
		rec_c.z = cw_c ? zi_c + at_c : zi_c - at_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= rec_c;
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

// ===== rtl/pcc_post.sv =====
// ----------------------------------------------------------------------------
// pcc_post: gain correction, rounding and saturation
// Three stages: split gain multiply, angle and Q32 rounding; partial product
// sum, cartesian saturation and axis case; length rounding and final word assembly.
// ----------------------------------------------------------------------------
module pcc_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  pcc_pkg::cordic_t   in_data,
	output logic               out_vld,
	output pcc_pkg::out_word_t out_word
);

	localparam int LO_W = pcc_pkg::SPLIT + pcc_pkg::GAIN_W;
	localparam int HI_W = pcc_pkg::MAG_W - pcc_pkg::SPLIT + pcc_pkg::GAIN_W;

	logic signed [pcc_pkg::CX_W-1:0]      xi_c, yi_c, rxs_c, rys_c;
	logic signed [pcc_pkg::Z_W-1:0]       za_c;
	logic [pcc_pkg::MAG_W-1:0]            mag_x_c;
	logic [LO_W-1:0]                      pp_lo_c;
	logic [HI_W-1:0]                      pp_hi_c;

	logic                                 vld_s1, func_s1, zero_x_s1, ovf_s1;
	logic signed [pcc_pkg::DATA_W-1:0]    y_raw_s1;
	logic [LO_W-1:0]                      pp_lo_s1;
	logic [HI_W-1:0]                      pp_hi_s1;
	logic signed [pcc_pkg::ANG_OUT_W-1:0] ang_s1;
	logic signed [pcc_pkg::RND_W-1:0]     rx_s1, ry_s1;

	logic [pcc_pkg::SUM_W-1:0]            sum_c;
	logic signed [pcc_pkg::DATA_W-1:0]    ox_c, oy_c, ang_c;
	logic                                 satx_c, saty_c;
	logic signed [pcc_pkg::DATA_W:0]      ye_c;
	logic [pcc_pkg::DATA_W:0]             mag_sp_c;

	logic                                 vld_s2, func_s2, zero_x_s2, ovf_s2;
	logic [pcc_pkg::MAG_W-1:0]            mag_q32_s2;
	logic [pcc_pkg::DATA_W:0]             mag_sp_s2;
	logic signed [pcc_pkg::DATA_W-1:0]    first_c_s2, second_s2;

	logic [pcc_pkg::MAG_W:0]              rnd_c;
	logic [pcc_pkg::DATA_W+1:0]           mag_full_c;
	logic                                 sat_c;
	pcc_pkg::out_word_t                   word_c;

	logic                                 vld_s3;
	pcc_pkg::out_word_t                   word_s3;

	// stage 1: gain multiply in two halves, angle and coordinate rounding
	always_comb begin
		xi_c    = in_data.x;
		yi_c    = in_data.y;
		mag_x_c = xi_c[pcc_pkg::CX_W-1] ? '0 : xi_c[pcc_pkg::MAG_W-1:0];
		pp_lo_c = LO_W'(mag_x_c[pcc_pkg::SPLIT-1:0]) * LO_W'(pcc_pkg::GAIN_Q30);
		pp_hi_c = HI_W'(mag_x_c[pcc_pkg::MAG_W-1:pcc_pkg::SPLIT]) * HI_W'(pcc_pkg::GAIN_Q30);
		za_c    = in_data.z + pcc_pkg::ANG_RND;
		rxs_c   = xi_c + pcc_pkg::CX_RND;
		rys_c   = yi_c + pcc_pkg::CX_RND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		func_s1   <= in_data.func;
		zero_x_s1 <= in_data.zero_x;
		ovf_s1    <= in_data.ovf;
		y_raw_s1  <= in_data.y_raw;
		pp_lo_s1  <= pp_lo_c;
		pp_hi_s1  <= pp_hi_c;
		ang_s1    <= za_c[pcc_pkg::Z_W-1:pcc_pkg::ANG_SH];
		rx_s1     <= rxs_c[pcc_pkg::CX_W-1:pcc_pkg::GUARD_SH];
		ry_s1     <= rys_c[pcc_pkg::CX_W-1:pcc_pkg::GUARD_SH];
	end

	// stage 2: sum partial products, saturate cartesian results, axis case
	always_comb begin
		sum_c = {pp_hi_s1, {pcc_pkg::SPLIT{1'b0}}}
			+ {{(pcc_pkg::SUM_W-LO_W){1'b0}}, pp_lo_s1};
		satx_c = (rx_s1 > pcc_pkg::SAT_MAX) || (rx_s1 < pcc_pkg::SAT_MIN);
		saty_c = (ry_s1 > pcc_pkg::SAT_MAX) || (ry_s1 < pcc_pkg::SAT_MIN);
		if (rx_s1 > pcc_pkg::SAT_MAX) begin
			ox_c = pcc_pkg::SAT_MAX;
		end else if (rx_s1 < pcc_pkg::SAT_MIN) begin
			ox_c = pcc_pkg::SAT_MIN;
		end else begin
			ox_c = rx_s1[pcc_pkg::DATA_W-1:0];
		end
		if (ry_s1 > pcc_pkg::SAT_MAX) begin
			oy_c = pcc_pkg::SAT_MAX;
		end else if (ry_s1 < pcc_pkg::SAT_MIN) begin
			oy_c = pcc_pkg::SAT_MIN;
		end else begin
			oy_c = ry_s1[pcc_pkg::DATA_W-1:0];
		end
		// x on the axis: angle from the sign of y alone
		if (zero_x_s1) begin
			if (y_raw_s1 > 0) begin
				ang_c = pcc_pkg::HALF_PI_Q16;
			end else if (y_raw_s1 < 0) begin
				ang_c = -pcc_pkg::HALF_PI_Q16;
			end else begin
				ang_c = '0;
			end
		end else begin
			ang_c = {{(pcc_pkg::DATA_W-pcc_pkg::ANG_OUT_W){ang_s1[pcc_pkg::ANG_OUT_W-1]}}, ang_s1};
		end
		ye_c     = {y_raw_s1[pcc_pkg::DATA_W-1], y_raw_s1};
		mag_sp_c = y_raw_s1[pcc_pkg::DATA_W-1] ? -ye_c : ye_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2    <= func_s1;
		zero_x_s2  <= zero_x_s1;
		ovf_s2     <= ovf_s1 | satx_c | saty_c;
		mag_q32_s2 <= sum_c[pcc_pkg::SUM_W-1:pcc_pkg::GAIN_W];
		mag_sp_s2  <= mag_sp_c;
		first_c_s2 <= ox_c;
		second_s2  <= (func_s1 == pcc_pkg::FUNC_TO_CART) ? oy_c : ang_c;
	end

	// stage 3: round the length to Q15.16 and saturate
	always_comb begin
		rnd_c = {1'b0, mag_q32_s2} + (pcc_pkg::MAG_W+1)'(32768);
		mag_full_c = zero_x_s2 ? {1'b0, mag_sp_s2} : rnd_c[pcc_pkg::MAG_W:pcc_pkg::GUARD_SH];
		sat_c = mag_full_c > {2'b00, pcc_pkg::SAT_MAX};
		word_c.second_out = second_s2;
		if (func_s2 == pcc_pkg::FUNC_TO_CART) begin
			word_c.first_out = first_c_s2;
			word_c.overflow  = ovf_s2;
		end else begin
			word_c.first_out = sat_c ? pcc_pkg::SAT_MAX : mag_full_c[pcc_pkg::DATA_W-1:0];
			word_c.overflow  = sat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		word_s3 <= word_c;
	end

	assign out_vld  = vld_s3;
	assign out_word = word_s3;

endmodule

// ===== rtl/polar_cartesian_converter.sv =====
// throughput: one word per cycle unless req_stall holds the request side; one
//   register stage per cordic micro-rotation, two input stages, three output
//   stages and an output buffer of ITERATIONS + 7 words; a credit count of words
//   in flight or buffered sets when the request side is stalled
// reset clears valid bits, buffer pointers and counts; no data is cleared
// ----------------------------------------------------------------------------
// polar_cartesian_converter: pipelined cordic coordinate converter
// Converts cartesian to polar or polar to cartesian per word, Q15.16 fixed
// point, with a credit-managed output buffer so the pipeline never stalls.
// ----------------------------------------------------------------------------
module polar_cartesian_converter #(
	parameter int ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pcc_pkg::in_word_t  req_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output pcc_pkg::out_word_t rsp_word
);

	localparam int DEPTH = ITERATIONS + 7;
	localparam int CAP   = DEPTH + 1;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = $clog2(CAP + 1);

	logic               acc_in, acc_out;
	logic               vld_c [ITERATIONS+1];
	pcc_pkg::cordic_t   data_c [ITERATIONS+1];
	logic               post_vld;
	pcc_pkg::out_word_t post_word;

	logic [OCC_W-1:0]   occ_q;
	logic [CNT_W-1:0]   fcnt_q;
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic               fifo_rd;
	pcc_pkg::out_word_t mem [DEPTH];
	logic               rsp_valid_q;
	pcc_pkg::out_word_t rsp_word_q;

	assign acc_in    = req_valid & ~req_stall;
	assign acc_out   = rsp_valid_q & ~rsp_stall;
	assign req_stall = (occ_q == OCC_W'(CAP));

	// input conditioning
	pcc_pre u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (acc_in),
		.in_word  (req_word),
		.out_vld  (vld_c[0]),
		.out_data (data_c[0])
	);

	// micro-rotation chain
	for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
		pcc_stage #(
			.IDX (g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld_c[g]),
			.in_data  (data_c[g]),
			.out_vld  (vld_c[g+1]),
			.out_data (data_c[g+1])
		);
	end

	// gain correction and rounding
	pcc_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_c[ITERATIONS]),
		.in_data  (data_c[ITERATIONS]),
		.out_vld  (post_vld),
		.out_word (post_word)
	);

	// words in flight or buffered, bounds intake to the buffer size plus the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(acc_in) - OCC_W'(acc_out);
		end
	end

	// output buffer control
	assign fifo_rd = (fcnt_q != '0) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q      <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			fcnt_q <= fcnt_q + CNT_W'(post_vld) - CNT_W'(fifo_rd);
			if (post_vld) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (fifo_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			rsp_valid_q <= fifo_rd | (rsp_valid_q & rsp_stall);
		end
	end

	// buffer storage with registered read into the response register
	always_ff @(posedge clk) begin
		if (post_vld) begin
			mem[wr_ptr_q] <= post_word;
		end
		if (fifo_rd) begin
			rsp_word_q <= mem[rd_ptr_q];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	// a write into a full buffer must coincide with a read
	assert property (@(posedge clk) disable iff (!arst_n)
		(post_vld && fcnt_q == CNT_W'(DEPTH)) |-> fifo_rd)
		else $error("output buffer overrun");

	// credit count stays within capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAP))
		else $error("credit count above capacity");

	// buffered words and the held response never exceed the credit count
	assert property (@(posedge clk) disable iff (!arst_n)
		(OCC_W'(fcnt_q) + OCC_W'(rsp_valid_q)) <= occ_q)
		else $error("buffer holds more words than were accepted");

	// a response appears only after a buffer read
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(fifo_rd))
		else $error("response valid without buffer read");

endmodule
